// ----- sv/fpm_pkg.sv -----
package fpm_pkg;

    // Channel count and index width (the channel field is two bits wide)
    localparam int NUM_CHANNELS = 3;
    localparam int CH_W = 2;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    localparam int TIME_W = 48;
    localparam int TALLY_W = 16;
    localparam int RATE_W = 24;
    localparam int CFG_W = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_STOP_TIMEOUT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_REPORT_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0] STOP_TIMEOUT_RESET = 32'd2000000;
    localparam logic [CFG_W-1:0] REPORT_INTERVAL_RESET = 32'd1000000;

    // Request types
    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        RK_START = 2'd0,
        RK_RATE  = 2'd1,
        RK_STOP  = 2'd2
    } report_kind_t;

    // One channel's entry in the state memory
    typedef struct packed {
        logic               active;
        logic [TALLY_W-1:0] tally;
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  last_report;
        logic [TIME_W-1:0]  last_pulse;
    } chan_state_t;

    // One report item
    typedef struct packed {
        logic [CH_W-1:0]   channel;
        report_kind_t      kind;
        logic [RATE_W-1:0] rate;
        logic [TIME_W-1:0] elapsed;
    } result_t;

    // now - then, clamped at zero when time went backwards
    function automatic logic [TIME_W-1:0] time_since(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] then_t
    );
        return (now >= then_t) ? (now - then_t) : '0;
    endfunction

    // time_since(now, then) >= threshold
    function automatic logic is_due(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] then_t,
        input logic [CFG_W-1:0]  thr
    );
        return time_since(now, then_t) >= {{(TIME_W - CFG_W){1'b0}}, thr};
    endfunction

endpackage

// ----- sv/fpm_in_if.sv -----
interface fpm_in_if import fpm_pkg::*;;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] timestamp_us;

    modport source (output valid, req_type, channel, timestamp_us, input ready);
    modport sink (input valid, req_type, channel, timestamp_us, output ready);
endinterface

// ----- sv/fpm_out_if.sv -----
interface fpm_out_if import fpm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel_out;
    logic [1:0]        report_kind;
    logic [RATE_W-1:0] rate_milli_lpm;
    logic [TIME_W-1:0] elapsed_us;
    logic              last_of_run;

    modport source (output valid, channel_out, report_kind, rate_milli_lpm, elapsed_us,
                    last_of_run, input ready);
    modport sink (input valid, channel_out, report_kind, rate_milli_lpm, elapsed_us,
                  last_of_run, output ready);
endinterface

// ----- sv/fpm_cfg_if.sv -----
interface fpm_cfg_if import fpm_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ----- sv/fpm_rate_calc.sv -----
// Rate in mL/min from a pulse tally: floor(tally * 400 / 3)
// 400 = 3 * 133 + 1, so the result is 133 * tally + floor(tally / 3).
module fpm_rate_calc import fpm_pkg::*;
(
    input  logic [TALLY_W-1:0] tally,
    output logic [RATE_W-1:0]  rate
);

    logic [RATE_W-1:0] times133;
    logic [31:0]       third_prod;
    logic [RATE_W-1:0] third;

    // tally / 3 via reciprocal 43691 / 2^17, exact for 16-bit values
    assign third_prod = {16'd0, tally} * 32'd43691;
    assign third = RATE_W'(third_prod[31:17]);
    assign times133 = RATE_W'({8'd0, tally} * 24'd133);
    assign rate = times133 + third;

endmodule

// ----- sv/multi_channel_flow_pulse_meter.sv -----
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   req_type, channel, timestamp_us
// rpt      out  valid/ready   channel_out, report_kind, rate_milli_lpm, elapsed_us, last_of_run
// cfg      in   valid/ready   reg_index, wr_data (always ready)
//
// A pulse steps through accept, start check, rate check with write-back and flush; a tick
// steps through accept, one state memory read per channel (written back when active) and flush.
// The channel state memory is read through a register; a pulse on a channel
// past the last one is dropped in the accept cycle.
// Reset clears the per-entry valid bits; an unwritten entry reads as inactive and zero.
// A full output register stalls the sequencer only when a further report must leave.
module multi_channel_flow_pulse_meter import fpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    fpm_in_if.sink   req,
    fpm_out_if.source rpt,
    fpm_cfg_if.sink  cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PULSE_A,
        ST_PULSE_B,
        ST_TICK,
        ST_FLUSH
    } state_t;

    state_t            state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [TIME_W-1:0] now_reg, now_next;
    chan_state_t       work_reg, work_next;
    logic              pend_valid_reg, pend_valid_next;
    result_t           pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic              out_last_reg, out_last_next;

    logic [CFG_W-1:0]  stop_reg, intv_reg;

    // State memory and its valid bits
    chan_state_t       mem_q [NUM_CHANNELS];
    chan_state_t       rd_data_reg;
    logic              rd_hit_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic              rd_en, wr_en;
    logic [CH_W-1:0]   rd_addr, wr_addr;
    chan_state_t       wr_data;
    chan_state_t       cur;

    logic              out_free, emit_ok, emit_req;
    result_t           emit_data;
    logic [RATE_W-1:0] rate_val;

    chan_state_t       ea, eb, et;
    logic              start_now, rate_due, stop_due, tick_rep_due;

    fpm_rate_calc u_rate (
        .tally (work_reg.tally),
        .rate  (rate_val)
    );

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg <= STOP_TIMEOUT_RESET;
            intv_reg <= REPORT_INTERVAL_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_STOP_TIMEOUT:    stop_reg <= cfg.wr_data;
                REG_REPORT_INTERVAL: intv_reg <= cfg.wr_data;
                default:             ;
            endcase
        end
    end

    // Memory array: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_q[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem_q[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    assign cur = rd_hit_reg ? rd_data_reg : '0;

    // Pulse, first step: count and flow start
    always_comb
    begin
        ea = cur;
        start_now = !cur.active;
        ea.tally = (cur.tally == TALLY_MAX) ? cur.tally : cur.tally + TALLY_W'(1);
        ea.last_pulse = now_reg;
        if (start_now)
        begin
            ea.active = 1'b1;
            ea.start_time = now_reg;
            ea.last_report = now_reg;
            ea.tally = TALLY_W'(1);
        end
    end

    // Pulse, second step: rate report when due
    always_comb
    begin
        eb = work_reg;
        rate_due = is_due(now_reg, work_reg.last_report, intv_reg);
        if (rate_due)
        begin
            eb.tally = '0;
            eb.last_report = now_reg;
        end
    end

    // Tick: stop or zero-rate report for the entry at hand
    always_comb
    begin
        et = cur;
        stop_due = cur.active && is_due(now_reg, cur.last_pulse, stop_reg);
        tick_rep_due = cur.active && !stop_due && is_due(now_reg, cur.last_report, intv_reg);
        if (stop_due)
            et.active = 1'b0;
        else if (tick_rep_due)
        begin
            et.tally = '0;
            et.last_report = now_reg;
        end
    end

    assign out_free = !out_valid_reg || rpt.ready;
    assign emit_ok = !pend_valid_reg || out_free;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        ch_next = ch_reg;
        now_next = now_reg;
        work_next = work_reg;
        pend_valid_next = pend_valid_reg;
        pend_next = pend_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        out_last_next = out_last_reg;
        rd_en = 1'b0;
        rd_addr = ch_reg;
        wr_en = 1'b0;
        wr_addr = ch_reg;
        wr_data = eb;
        emit_req = 1'b0;
        emit_data = '0;
        emit_data.channel = ch_reg;
        req.ready = (state_reg == ST_IDLE);

        if (rpt.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    ch_next = req.channel;
                    now_next = req.timestamp_us;
                    if (req.req_type == REQ_TICK)
                    begin
                        ch_next = '0;
                        rd_en = 1'b1;
                        rd_addr = '0;
                        state_next = ST_TICK;
                    end
                    else if (req.channel <= LAST_CH)
                    begin
                        rd_en = 1'b1;
                        rd_addr = req.channel;
                        state_next = ST_PULSE_A;
                    end
                end
            end
            ST_PULSE_A:
            begin
                emit_req = start_now;
                emit_data.kind = RK_START;
                if (!start_now || emit_ok)
                begin
                    work_next = ea;
                    state_next = ST_PULSE_B;
                end
            end
            ST_PULSE_B:
            begin
                emit_req = rate_due;
                emit_data.kind = RK_RATE;
                emit_data.rate = rate_val;
                emit_data.elapsed = time_since(now_reg, work_reg.start_time);
                if (!rate_due || emit_ok)
                begin
                    wr_en = 1'b1;
                    wr_data = eb;
                    state_next = ST_FLUSH;
                end
            end
            ST_TICK:
            begin
                emit_req = stop_due || tick_rep_due;
                emit_data.kind = stop_due ? RK_STOP : RK_RATE;
                emit_data.elapsed = time_since(now_reg, cur.start_time);
                if (!emit_req || emit_ok)
                begin
                    wr_en = cur.active;
                    wr_data = et;
                    if (ch_reg == LAST_CH)
                        state_next = ST_FLUSH;
                    else
                    begin
                        ch_next = ch_reg + CH_W'(1);
                        rd_en = 1'b1;
                        rd_addr = ch_reg + CH_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = pend_reg;
                    out_last_next = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // New report goes to the holding slot; the held one moves out, not last
        if (emit_req && emit_ok)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next = pend_reg;
                out_last_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next = emit_data;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg <= '0;
            now_reg <= '0;
            work_reg <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg <= ch_next;
            now_reg <= now_next;
            work_reg <= work_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg <= pend_next;
            out_valid_reg <= out_valid_next;
            out_reg <= out_next;
            out_last_reg <= out_last_next;
        end
    end

    assign rpt.valid = out_valid_reg;
    assign rpt.channel_out = out_reg.channel;
    assign rpt.report_kind = out_reg.kind;
    assign rpt.rate_milli_lpm = out_reg.rate;
    assign rpt.elapsed_us = out_reg.elapsed;
    assign rpt.last_of_run = out_last_reg;

    // A held report never outlives its item
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("held report left in idle");

    // Write-back only from the evaluation steps
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_PULSE_B || state_reg == ST_TICK))
        else $error("state memory written outside evaluation");

    // Tick walk stays within the channel range
    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TICK |-> ch_reg <= LAST_CH)
        else $error("tick channel out of range");

    // A finished report is never overwritten while waiting
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rpt.ready) |=> out_valid_reg && $stable(out_reg))
        else $error("waiting report overwritten");

endmodule

// ----- tb/multi_channel_flow_pulse_meter_checker.sv -----
module multi_channel_flow_pulse_meter_checker import fpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fpm_in_if    req,
    fpm_out_if   rpt,
    fpm_cfg_if   cfg,
    output int   mismatches,
    output int   reports_due
);

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        report_kind_t      kind;
        logic [RATE_W-1:0] rate;
        logic [TIME_W-1:0] elapsed;
        logic              last;
    } flow_report_t;

    // Shadow of the per-channel meter state and the two registers
    logic [TALLY_W-1:0] tally       [NUM_CHANNELS];
    logic [TIME_W-1:0]  started_at  [NUM_CHANNELS];
    logic [TIME_W-1:0]  reported_at [NUM_CHANNELS];
    logic [TIME_W-1:0]  pulsed_at   [NUM_CHANNELS];
    logic               running     [NUM_CHANNELS];
    logic [CFG_W-1:0]   stop_us;
    logic [CFG_W-1:0]   interval_us;

    flow_report_t due_reports[$];

    // Elapsed time, clamped to zero when the clock went backwards
    function automatic logic [TIME_W-1:0] span(input logic [TIME_W-1:0] now,
                                               input logic [TIME_W-1:0] since);
        return (now >= since) ? (now - since) : '0;
    endfunction

    function automatic logic reached(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] since,
                                     input logic [CFG_W-1:0]  limit);
        return span(now, since) >= {{(TIME_W - CFG_W){1'b0}}, limit};
    endfunction

    task automatic queue_report(input logic [CH_W-1:0] ch, input report_kind_t kind,
                                input logic [RATE_W-1:0] rate,
                                input logic [TIME_W-1:0] elapsed);
        flow_report_t r;
        r.channel = ch;
        r.kind    = kind;
        r.rate    = rate;
        r.elapsed = elapsed;
        r.last    = 1'b0;
        due_reports.push_back(r);
    endtask

    // Work out the reports that one accepted request causes
    task automatic predict_meter(input logic kind, input logic [CH_W-1:0] ch,
                                 input logic [TIME_W-1:0] now);
        int           before_n;
        logic [31:0]  product;
        flow_report_t tail;
        before_n = due_reports.size();
        if (kind == REQ_PULSE)
        begin
            if (ch < NUM_CHANNELS)
            begin
                if (tally[ch] != TALLY_MAX)
                    tally[ch] = tally[ch] + TALLY_W'(1);
                pulsed_at[ch] = now;
                if (!running[ch])
                begin
                    running[ch]     = 1'b1;
                    started_at[ch]  = now;
                    reported_at[ch] = now;
                    tally[ch]       = TALLY_W'(1);
                    queue_report(ch, RK_START, '0, '0);
                end
                if (reached(now, reported_at[ch], interval_us))
                begin
                    product = {16'b0, tally[ch]} * 32'd400;
                    queue_report(ch, RK_RATE, RATE_W'(product / 32'd3),
                                 span(now, started_at[ch]));
                    tally[ch]       = '0;
                    reported_at[ch] = now;
                end
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (running[i])
                begin
                    if (reached(now, pulsed_at[i], stop_us))
                    begin
                        running[i] = 1'b0;
                        queue_report(CH_W'(i), RK_STOP, '0, span(now, started_at[i]));
                    end
                    else if (reached(now, reported_at[i], interval_us))
                    begin
                        queue_report(CH_W'(i), RK_RATE, '0, span(now, started_at[i]));
                        tally[i]       = '0;
                        reported_at[i] = now;
                    end
                end
            end
        end
        // flag the final report of this request
        if (due_reports.size() > before_n)
        begin
            tail      = due_reports.pop_back();
            tail.last = 1'b1;
            due_reports.push_back(tail);
        end
    endtask

    // Print the item seen on the report channel
    task automatic show_actual();
        $write("ch=%0d kind=%0d rate=%0d ", rpt.channel_out, rpt.report_kind,
               rpt.rate_milli_lpm);
        $display("elapsed=%0d last=%0d", rpt.elapsed_us, rpt.last_of_run);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        flow_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                tally[i]       = '0;
                started_at[i]  = '0;
                reported_at[i] = '0;
                pulsed_at[i]   = '0;
                running[i]     = 1'b0;
            end
            stop_us     = STOP_TIMEOUT_RESET;
            interval_us = REPORT_INTERVAL_RESET;
            due_reports.delete();
            mismatches  = 0;
            reports_due = 0;
        end
        else
        begin
            // outgoing report against the oldest expectation
            if (rpt.valid && rpt.ready)
            begin
                if (due_reports.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $write("unexpected report: ");
                        show_actual();
                    end
                    mismatches++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (rpt.channel_out !== want.channel || rpt.report_kind !== want.kind ||
                        rpt.rate_milli_lpm !== want.rate || rpt.elapsed_us !== want.elapsed ||
                        rpt.last_of_run !== want.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $write("report differs: expected ch=%0d kind=%0d rate=%0d ",
                                   want.channel, want.kind, want.rate);
                            $write("elapsed=%0d last=%0d, got ", want.elapsed, want.last);
                            show_actual();
                        end
                        mismatches++;
                    end
                end
            end
            // register write
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.reg_index == REG_STOP_TIMEOUT)
                    stop_us = cfg.wr_data;
                else if (cfg.reg_index == REG_REPORT_INTERVAL)
                    interval_us = cfg.wr_data;
            end
            // accepted request
            if (req.valid && req.ready)
                predict_meter(req.req_type, req.channel, req.timestamp_us);
            reports_due = due_reports.size();
        end
    end

endmodule

// ----- tb/multi_channel_flow_pulse_meter_tb.sv -----
module multi_channel_flow_pulse_meter_tb;
    import fpm_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 120;
    localparam int PHASE_ITEMS    = 36;
    localparam int NUM_PHASES     = 5;
    localparam int TIMEOUT_CYCLES = 2000000;

    logic clk = 1'b0;
    logic rst_n;

    fpm_in_if  req_if ();
    fpm_out_if rpt_if ();
    fpm_cfg_if cfg_if ();

    int mismatches;
    int reports_due;

    logic              quiet = 1'b0;
    int                hold_requests = 0;
    int                holds_served = 0;
    int                hold_left = 0;
    logic [TIME_W-1:0] now_us;

    multi_channel_flow_pulse_meter u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rpt   (rpt_if),
        .cfg   (cfg_if)
    );

    multi_channel_flow_pulse_meter_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rpt         (rpt_if),
        .cfg         (cfg_if),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("multi_channel_flow_pulse_meter: mismatch");
        $finish;
    end

    // Report sink: random back-pressure, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rpt_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            rpt_if.ready <= 1'b0;
        end
        else
        begin
            rpt_if.ready <= quiet || ($urandom_range(99) >= 28);
        end
    end

    // Present one request and wait until it is taken
    task automatic offer_request(input logic kind, input logic [CH_W-1:0] ch,
                                 input logic [TIME_W-1:0] ts);
        while (!quiet && $urandom_range(99) < 28)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.channel      <= ch;
        req_if.timestamp_us <= ts;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    task automatic drain_reports();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
    endtask

    // Idle the block fully, then write both registers
    task automatic configure(input logic [CFG_W-1:0] stop_val,
                             input logic [CFG_W-1:0] interval_val);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= REG_STOP_TIMEOUT;
        cfg_if.wr_data   <= stop_val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.reg_index <= REG_REPORT_INTERVAL;
        cfg_if.wr_data   <= interval_val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly time moving forward in random steps up to step_max; some wild times
    // and pulses on the unused channel mixed in
    task automatic random_request(input int unsigned step_max, output bit counted);
        int unsigned       roll;
        logic [TIME_W-1:0] wild;
        roll    = $urandom_range(99);
        wild    = {16'($urandom()), 32'($urandom())};
        counted = 1'b1;
        if (roll < 5)
        begin
            offer_request(REQ_PULSE, CH_W'(NUM_CHANNELS), wild);
            counted = 1'b0;
        end
        else if (roll < 13)
        begin
            offer_request(($urandom_range(1) == 1) ? REQ_TICK : REQ_PULSE,
                          CH_W'($urandom_range(NUM_CHANNELS - 1)), wild);
            if ($urandom_range(1) == 1)
                now_us = wild;
        end
        else
        begin
            now_us = now_us + $urandom_range(step_max);
            if ($urandom_range(99) < 65)
                offer_request(REQ_PULSE, CH_W'($urandom_range(NUM_CHANNELS - 1)), now_us);
            else
                offer_request(REQ_TICK, CH_W'($urandom_range(3)), now_us);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] ph_stop;
        logic [CFG_W-1:0] ph_interval;
        int unsigned      ph_step;
        int               done;
        bit               counted;

        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_PULSE;
        req_if.channel      = '0;
        req_if.timestamp_us = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.reg_index    = REG_STOP_TIMEOUT;
        cfg_if.wr_data      = '0;
        rpt_if.ready        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: start, rate, unused channel, nothing due, stop,
        // time going backwards
        offer_request(REQ_PULSE, CH_W'(0), 48'd0);
        offer_request(REQ_PULSE, CH_W'(0), 48'd1000000);
        offer_request(REQ_PULSE, CH_W'(NUM_CHANNELS), 48'd5);
        offer_request(REQ_PULSE, CH_W'(1), 48'd1500000);
        offer_request(REQ_TICK, CH_W'(0), 48'd1500001);
        offer_request(REQ_TICK, CH_W'(0), 48'd3100000);
        offer_request(REQ_PULSE, LAST_CH, 48'd3100000);
        offer_request(REQ_TICK, CH_W'(0), 48'd0);
        offer_request(REQ_PULSE, CH_W'(1), 48'd100);
        offer_request(REQ_TICK, CH_W'(0), '1);

        // Zero interval: a starting pulse also reports; one tick gives three
        configure('1, '0);
        offer_request(REQ_PULSE, CH_W'(0), '1);
        offer_request(REQ_PULSE, CH_W'(1), 48'd7);
        offer_request(REQ_PULSE, LAST_CH, 48'd8);
        offer_request(REQ_TICK, CH_W'(0), '1);

        // Shortest thresholds
        configure(32'd1, 32'd1);
        offer_request(REQ_PULSE, CH_W'(0), '1);
        offer_request(REQ_TICK, CH_W'(0), 48'd0);
        offer_request(REQ_PULSE, CH_W'(1), 48'd10);
        offer_request(REQ_TICK, CH_W'(0), 48'd11);

        // Random phases
        now_us = 48'd5000000;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            unique case (ph)
                0:
                begin
                    ph_stop = 32'd5000;
                    ph_interval = 32'd1000;
                    ph_step = 1500;
                end
                1:
                begin
                    ph_stop = 32'd1;
                    ph_interval = 32'd1;
                    ph_step = 3;
                end
                2:
                begin
                    ph_stop = 32'd3000;
                    ph_interval = '1;
                    ph_step = 2500;
                end
                3:
                begin
                    ph_stop = '1;
                    ph_interval = 32'd700;
                    ph_step = 900;
                end
                default:
                begin
                    ph_stop = STOP_TIMEOUT_RESET;
                    ph_interval = REPORT_INTERVAL_RESET;
                    ph_step = 1500000;
                end
            endcase
            configure(ph_stop, ph_interval);
            quiet = (ph == 3);
            done  = 0;
            while (done < PHASE_ITEMS)
            begin
                random_request(ph_step, counted);
                if (counted)
                begin
                    done++;
                    // long receiver hold-off while requests keep coming
                    if (ph == 0 && done == 8)
                        hold_requests++;
                    // sender waits out every outstanding report
                    if (ph == 0 && done == 25)
                        drain_reports();
                end
            end
            quiet = 1'b0;
        end

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && reports_due == 0)
            $display("multi_channel_flow_pulse_meter: match");
        else
            $display("multi_channel_flow_pulse_meter: mismatch");
        $finish;
    end

endmodule
